>>> design/ttpq_pkg.sv
`timescale 1ns / 1ps

package ttpq_pkg;

	localparam int HEAP_DEPTH   = 64;
	localparam int HEAP_SLOTS   = HEAP_DEPTH + 1;  // spare slot for push-then-pop in rebuild
	localparam int HEAP_AW      = $clog2(HEAP_SLOTS);
	localparam int HEAP_CW      = $clog2(HEAP_SLOTS + 1);
	localparam int RUNNER_DEPTH = 16;
	localparam int RUN_AW       = $clog2(RUNNER_DEPTH);
	localparam int RUN_CW       = $clog2(RUNNER_DEPTH + 1);
	localparam int PILE_DEPTH   = 1024;
	localparam int PILE_AW      = $clog2(PILE_DEPTH);
	localparam int PILE_CW      = $clog2(PILE_DEPTH + 1);

	localparam int GOOD_W   = 7;
	localparam int RLIM_W   = 5;
	localparam int CFG_W    = 7;
	localparam int CFG_IW   = 1;
	localparam int GOOD_RST = 64;
	localparam int RLIM_RST = 16;

	localparam logic [CFG_IW-1:0] REG_GOOD_LIMIT   = 1'd0;
	localparam logic [CFG_IW-1:0] REG_RUNNER_LIMIT = 1'd1;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// heap unit commands
	localparam logic [1:0] HOP_PUSH = 2'd0;
	localparam logic [1:0] HOP_POP  = 2'd1;
	localparam logic [1:0] HOP_PEEK = 2'd2;
	localparam logic [1:0] HOP_LAST = 2'd3;

	// runner list commands
	localparam logic [1:0] ROP_INSERT = 2'd0;
	localparam logic [1:0] ROP_EVICT  = 2'd1;
	localparam logic [1:0] ROP_MAX    = 2'd2;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] handle;
		logic [31:0] score;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic       go;
		logic [1:0] op;
		entry_t     ent;
	} hcmd_t;

	typedef struct packed {
		logic               done;
		logic [HEAP_CW-1:0] cnt;
		entry_t             res;
	} hstat_t;

	typedef struct packed {
		logic       go;
		logic [1:0] op;
		entry_t     ent;
	} rcmd_t;

	typedef struct packed {
		logic              done;
		logic [RUN_CW-1:0] cnt;
		entry_t            min;
		entry_t            res;
	} rstat_t;

endpackage

>>> design/ttpq_ram.sv
`timescale 1ns / 1ps

module ttpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/ttpq_heap.sv
`timescale 1ns / 1ps

// Min-heap engine: one RAM, one score comparator, sift one level per step.
module ttpq_heap (
	input  logic            clk,
	input  logic            arst_n,
	input  ttpq_pkg::hcmd_t cmd,
	output ttpq_pkg::hstat_t stat
);

	localparam logic [3:0] H_IDLE   = 4'd0;
	localparam logic [3:0] H_PU_CHK = 4'd1;
	localparam logic [3:0] H_PU_CMP = 4'd2;
	localparam logic [3:0] H_PK_W   = 4'd3;
	localparam logic [3:0] H_LT_W   = 4'd4;
	localparam logic [3:0] H_PO_RT  = 4'd5;
	localparam logic [3:0] H_PO_LST = 4'd6;
	localparam logic [3:0] H_PO_CHK = 4'd7;
	localparam logic [3:0] H_PO_L   = 4'd8;
	localparam logic [3:0] H_PO_R   = 4'd9;
	localparam logic [3:0] H_PO_CMP = 4'd10;

	logic [3:0]                     state_q;
	logic [ttpq_pkg::HEAP_CW-1:0]   count_q;
	logic [ttpq_pkg::HEAP_AW-1:0]   pos_q;
	logic [ttpq_pkg::HEAP_AW-1:0]   cidx_q;
	ttpq_pkg::entry_t               ent_q;
	ttpq_pkg::entry_t               child_q;
	ttpq_pkg::entry_t               res_q;
	logic                           done_q;

	logic                           we;
	logic [ttpq_pkg::HEAP_AW-1:0]   waddr;
	logic [ttpq_pkg::HEAP_AW-1:0]   raddr;
	ttpq_pkg::entry_t               wdata;
	ttpq_pkg::entry_t               rdata;

	logic [ttpq_pkg::HEAP_AW-1:0]   parent;
	logic [ttpq_pkg::HEAP_AW:0]     lchild;
	logic [ttpq_pkg::HEAP_AW:0]     rchild;
	logic [ttpq_pkg::HEAP_AW:0]     cnt_x;
	logic                           l_in;
	logic                           r_in;
	logic [31:0]                    cmp_a;
	logic [31:0]                    cmp_b;
	logic                           lt;

	ttpq_ram #(
		.WIDTH(ttpq_pkg::ENTRY_W),
		.DEPTH(ttpq_pkg::HEAP_SLOTS)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign parent = ttpq_pkg::HEAP_AW'((pos_q - 1'b1) >> 1);
	assign lchild = {pos_q, 1'b1};
	assign rchild = lchild + 1'b1;
	assign cnt_x  = (ttpq_pkg::HEAP_AW + 1)'(count_q);
	assign l_in   = lchild < cnt_x;
	assign r_in   = rchild < cnt_x;

	// shared comparator
	always_comb begin
		cmp_a = child_q.score;
		cmp_b = ent_q.score;
		case (state_q)
			H_PU_CMP: begin
				cmp_a = ent_q.score;
				cmp_b = rdata.score;
			end
			H_PO_R: begin
				cmp_a = rdata.score;
				cmp_b = child_q.score;
			end
			default: ;
		endcase
	end
	assign lt = cmp_a < cmp_b;

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = ent_q;
		raddr = '0;
		unique case (state_q)
			H_IDLE: begin
				if (cmd.go && cmd.op == ttpq_pkg::HOP_LAST) begin
					raddr = ttpq_pkg::HEAP_AW'(count_q - 1'b1);
				end
			end
			H_PU_CHK: begin
				if (pos_q == '0) begin
					we = 1'b1;
				end else begin
					raddr = parent;
				end
			end
			H_PU_CMP: begin
				we    = 1'b1;
				waddr = pos_q;
				wdata = lt ? rdata : ent_q;
			end
			H_PO_RT: raddr = ttpq_pkg::HEAP_AW'(count_q - 1'b1);
			H_PO_CHK: begin
				if (!l_in) begin
					we    = 1'b1;
					waddr = pos_q;
				end else begin
					raddr = ttpq_pkg::HEAP_AW'(lchild);
				end
			end
			H_PO_L: raddr = ttpq_pkg::HEAP_AW'(rchild);
			H_PO_CMP: begin
				we    = 1'b1;
				waddr = pos_q;
				wdata = lt ? child_q : ent_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (cmd.go) begin
						case (cmd.op)
							ttpq_pkg::HOP_PUSH: begin
								ent_q   <= cmd.ent;
								pos_q   <= ttpq_pkg::HEAP_AW'(count_q);
								count_q <= count_q + 1'b1;
								state_q <= H_PU_CHK;
							end
							ttpq_pkg::HOP_POP:  state_q <= H_PO_RT;
							ttpq_pkg::HOP_PEEK: state_q <= H_PK_W;
							default: begin
								count_q <= count_q - 1'b1;
								state_q <= H_LT_W;
							end
						endcase
					end
				end
				H_PU_CHK: begin
					if (pos_q == '0) begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						state_q <= H_PU_CMP;
					end
				end
				H_PU_CMP: begin
					if (lt) begin
						pos_q   <= parent;
						state_q <= H_PU_CHK;
					end else begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end
				end
				H_PK_W, H_LT_W: begin
					res_q   <= rdata;
					done_q  <= 1'b1;
					state_q <= H_IDLE;
				end
				H_PO_RT: begin
					res_q   <= rdata;
					count_q <= count_q - 1'b1;
					if (count_q == ttpq_pkg::HEAP_CW'(1)) begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						state_q <= H_PO_LST;
					end
				end
				H_PO_LST: begin
					ent_q   <= rdata;
					pos_q   <= '0;
					state_q <= H_PO_CHK;
				end
				H_PO_CHK: begin
					if (!l_in) begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						state_q <= H_PO_L;
					end
				end
				H_PO_L: begin
					child_q <= rdata;
					cidx_q  <= ttpq_pkg::HEAP_AW'(lchild);
					state_q <= r_in ? H_PO_R : H_PO_CMP;
				end
				H_PO_R: begin
					if (lt) begin
						child_q <= rdata;
						cidx_q  <= ttpq_pkg::HEAP_AW'(rchild);
					end
					state_q <= H_PO_CMP;
				end
				H_PO_CMP: begin
					if (lt) begin
						pos_q   <= cidx_q;
						state_q <= H_PO_CHK;
					end else begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign stat.done = done_q;
	assign stat.cnt  = count_q;
	assign stat.res  = res_q;

endmodule

>>> design/ttpq_runner.sv
`timescale 1ns / 1ps

// Ascending runner-up list; insert and evict move one entry per cycle.
module ttpq_runner (
	input  logic             clk,
	input  logic             arst_n,
	input  ttpq_pkg::rcmd_t  cmd,
	output ttpq_pkg::rstat_t stat
);

	localparam logic [1:0] R_IDLE = 2'd0;
	localparam logic [1:0] R_INS  = 2'd1;
	localparam logic [1:0] R_EV   = 2'd2;

	logic [1:0]                   state_q;
	logic [ttpq_pkg::RUN_CW-1:0]  count_q;
	logic [ttpq_pkg::RUN_CW-1:0]  i_q;
	ttpq_pkg::entry_t             ent_q;
	ttpq_pkg::entry_t             res_q;
	logic                         done_q;
	ttpq_pkg::entry_t             arr_q [ttpq_pkg::RUNNER_DEPTH];

	logic [ttpq_pkg::RUN_AW-1:0]  rd_idx;
	ttpq_pkg::entry_t             rd_ent;
	logic                         lt;

	always_comb begin
		case (state_q)
			R_INS:   rd_idx = ttpq_pkg::RUN_AW'(i_q - 1'b1);
			R_EV:    rd_idx = ttpq_pkg::RUN_AW'(i_q + 1'b1);
			default: rd_idx = ttpq_pkg::RUN_AW'(count_q - 1'b1);
		endcase
	end
	assign rd_ent = arr_q[rd_idx];
	assign lt     = rd_ent.score < ent_q.score;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (cmd.go) begin
						case (cmd.op)
							ttpq_pkg::ROP_INSERT: begin
								ent_q   <= cmd.ent;
								i_q     <= count_q;
								state_q <= R_INS;
							end
							ttpq_pkg::ROP_EVICT: begin
								res_q   <= arr_q[0];
								count_q <= count_q - 1'b1;
								i_q     <= '0;
								state_q <= R_EV;
							end
							default: begin
								res_q   <= rd_ent;
								count_q <= count_q - 1'b1;
								done_q  <= 1'b1;
							end
						endcase
					end
				end
				R_INS: begin
					if (i_q == '0 || lt) begin
						arr_q[ttpq_pkg::RUN_AW'(i_q)] <= ent_q;
						count_q <= count_q + 1'b1;
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end else begin
						arr_q[ttpq_pkg::RUN_AW'(i_q)] <= rd_ent;
						i_q <= i_q - 1'b1;
					end
				end
				R_EV: begin
					if (i_q < count_q) begin
						arr_q[ttpq_pkg::RUN_AW'(i_q)] <= rd_ent;
						i_q <= i_q + 1'b1;
					end else begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign stat.done = done_q;
	assign stat.cnt  = count_q;
	assign stat.min  = arr_q[0];
	assign stat.res  = res_q;

endmodule

>>> design/three_tier_top_m_priority_queue.sv
`timescale 1ns / 1ps

// Three-tier top-m priority queue: min-heap of the best m entries, sorted
// runner-up list of r entries, and an append-only overflow pile.
//
// Command channel: a transfer happens when start is high and busy is low;
// op, item_id, item_handle and item_score are sampled then. busy stays high
// until the result strobe. Exactly one result per command: done is high for
// one cycle with got_entry, out_* and dropped; the receiver cannot stall it,
// and a new start may be taken in that same cycle.
// Config: cfg_we writes cfg_data into register cfg_index (0 good_limit,
// 1 runner_limit) at once; write only while busy is low.
// Time from transfer to done depends on the heap sift (one RAM port; going
// up, read the parent, then compare and write; going down, read the left
// child, then the right child where there is one, then compare and write)
// and on the runner list shift (one entry a cycle). A dequeue that finds
// heap and runner list empty first rebuilds the heap from the pile. One
// command at a time.
// Reset: all counts zero, limits 64 and 16; the stores need no clearing.
module three_tier_top_m_priority_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic [31:0]                   item_id,
	input  logic [31:0]                   item_handle,
	input  logic [31:0]                   item_score,
	input  logic                          cfg_we,
	input  logic [ttpq_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [ttpq_pkg::CFG_W-1:0]    cfg_data,
	output logic                          done,
	output logic                          got_entry,
	output logic [31:0]                   out_id,
	output logic [31:0]                   out_handle,
	output logic [31:0]                   out_score,
	output logic                          dropped
);

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_EQ        = 5'd1;
	localparam logic [4:0] S_EQ_PEEK_W = 5'd2;
	localparam logic [4:0] S_EQ_POP_W  = 5'd3;
	localparam logic [4:0] S_EQ_PUSH_W = 5'd4;
	localparam logic [4:0] S_ADMIT     = 5'd5;
	localparam logic [4:0] S_AD_EV_W   = 5'd6;
	localparam logic [4:0] S_AD_INS_W  = 5'd7;
	localparam logic [4:0] S_DQ        = 5'd8;
	localparam logic [4:0] S_RB_RD     = 5'd9;
	localparam logic [4:0] S_RB_PUSH   = 5'd10;
	localparam logic [4:0] S_RB_PUSH_W = 5'd11;
	localparam logic [4:0] S_RB_POP_W  = 5'd12;
	localparam logic [4:0] S_DQ_TAKE   = 5'd13;
	localparam logic [4:0] S_DQ_TAKE_W = 5'd14;
	localparam logic [4:0] S_DQ_RMAX_W = 5'd15;
	localparam logic [4:0] S_DQ_PUSH_W = 5'd16;
	localparam logic [4:0] S_FIN       = 5'd17;

	logic [4:0]                      state_q;
	logic [ttpq_pkg::GOOD_W-1:0]     good_limit_q;
	logic [ttpq_pkg::RLIM_W-1:0]     runner_limit_q;
	ttpq_pkg::entry_t                in_q;
	ttpq_pkg::entry_t                ad_q;
	logic                            admit_q;
	logic [ttpq_pkg::PILE_CW-1:0]    pcnt_q;
	logic [ttpq_pkg::PILE_CW-1:0]    i_q;
	ttpq_pkg::hcmd_t                 hcmd_q;
	ttpq_pkg::rcmd_t                 rcmd_q;
	ttpq_pkg::hstat_t                hstat;
	ttpq_pkg::rstat_t                rstat;
	logic                            done_q;
	logic                            got_q;
	logic                            drop_q;
	ttpq_pkg::entry_t                out_q;

	logic [ttpq_pkg::HEAP_CW-1:0]    m_eff;
	logic [ttpq_pkg::RUN_CW-1:0]     r_eff;
	logic [31:0]                     cmp_a;
	logic [31:0]                     cmp_b;
	logic                            lt;
	logic                            app_go;
	logic                            pile_full;
	ttpq_pkg::entry_t                app_ent;
	ttpq_pkg::entry_t                pile_rd;

	// clamp limits to the physical tier sizes; a good limit of zero counts as one
	always_comb begin
		if (good_limit_q == '0) begin
			m_eff = ttpq_pkg::HEAP_CW'(1);
		end else if (32'(good_limit_q) > 32'(ttpq_pkg::HEAP_DEPTH)) begin
			m_eff = ttpq_pkg::HEAP_CW'(ttpq_pkg::HEAP_DEPTH);
		end else begin
			m_eff = ttpq_pkg::HEAP_CW'(good_limit_q);
		end
		if (32'(runner_limit_q) > 32'(ttpq_pkg::RUNNER_DEPTH)) begin
			r_eff = ttpq_pkg::RUN_CW'(ttpq_pkg::RUNNER_DEPTH);
		end else begin
			r_eff = ttpq_pkg::RUN_CW'(runner_limit_q);
		end
	end

	// one score compare: new item vs heap root, or candidate vs runner minimum
	assign cmp_a = (state_q == S_ADMIT) ? rstat.min.score : hstat.res.score;
	assign cmp_b = (state_q == S_ADMIT) ? ad_q.score : in_q.score;
	assign lt    = cmp_a < cmp_b;

	// pile append decision while admitting a displaced entry
	always_comb begin
		app_go  = 1'b0;
		app_ent = ad_q;
		if (state_q == S_ADMIT) begin
			if (r_eff == '0) begin
				app_go = 1'b1;
			end else if (rstat.cnt >= r_eff) begin
				app_go = 1'b1;
				if (lt) begin
					app_ent = rstat.min;  // runner minimum is pushed out
				end
			end
		end
	end
	assign pile_full = pcnt_q >= ttpq_pkg::PILE_CW'(ttpq_pkg::PILE_DEPTH);

	ttpq_ram #(
		.WIDTH(ttpq_pkg::ENTRY_W),
		.DEPTH(ttpq_pkg::PILE_DEPTH)
	) u_pile (
		.clk  (clk),
		.we   (app_go && !pile_full),
		.waddr(ttpq_pkg::PILE_AW'(pcnt_q)),
		.wdata(app_ent),
		.raddr(ttpq_pkg::PILE_AW'(i_q)),
		.rdata(pile_rd)
	);

	ttpq_heap u_heap (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (hcmd_q),
		.stat  (hstat)
	);

	ttpq_runner u_runner (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (rcmd_q),
		.stat  (rstat)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_limit_q   <= ttpq_pkg::GOOD_W'(ttpq_pkg::GOOD_RST);
			runner_limit_q <= ttpq_pkg::RLIM_W'(ttpq_pkg::RLIM_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				ttpq_pkg::REG_GOOD_LIMIT:   good_limit_q   <= ttpq_pkg::GOOD_W'(cfg_data);
				ttpq_pkg::REG_RUNNER_LIMIT: runner_limit_q <= ttpq_pkg::RLIM_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pcnt_q    <= '0;
			hcmd_q.go <= 1'b0;
			rcmd_q.go <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			hcmd_q.go <= 1'b0;
			rcmd_q.go <= 1'b0;
			done_q    <= (state_q == S_FIN);
			if (app_go) begin
				if (pile_full) begin
					drop_q <= 1'b1;
				end else begin
					pcnt_q <= pcnt_q + 1'b1;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						in_q    <= '{id: item_id, handle: item_handle, score: item_score};
						got_q   <= 1'b0;
						drop_q  <= 1'b0;
						out_q   <= '0;
						state_q <= (op == ttpq_pkg::OP_DEQ) ? S_DQ : S_EQ;
					end
				end
				S_EQ: begin
					hcmd_q.go  <= 1'b1;
					hcmd_q.ent <= in_q;
					if (hstat.cnt < m_eff) begin
						hcmd_q.op <= ttpq_pkg::HOP_PUSH;
						admit_q   <= 1'b0;
						state_q   <= S_EQ_PUSH_W;
					end else begin
						hcmd_q.op <= ttpq_pkg::HOP_PEEK;
						state_q   <= S_EQ_PEEK_W;
					end
				end
				S_EQ_PEEK_W: begin
					if (hstat.done) begin
						if (lt) begin
							hcmd_q.go <= 1'b1;
							hcmd_q.op <= ttpq_pkg::HOP_POP;
							state_q   <= S_EQ_POP_W;
						end else begin
							ad_q    <= in_q;
							state_q <= S_ADMIT;
						end
					end
				end
				S_EQ_POP_W: begin
					if (hstat.done) begin
						ad_q       <= hstat.res;
						admit_q    <= 1'b1;
						hcmd_q.go  <= 1'b1;
						hcmd_q.op  <= ttpq_pkg::HOP_PUSH;
						hcmd_q.ent <= in_q;
						state_q    <= S_EQ_PUSH_W;
					end
				end
				S_EQ_PUSH_W: begin
					if (hstat.done) begin
						state_q <= admit_q ? S_ADMIT : S_FIN;
					end
				end
				S_ADMIT: begin
					if (r_eff == '0) begin
						state_q <= S_FIN;
					end else if (rstat.cnt < r_eff) begin
						rcmd_q.go  <= 1'b1;
						rcmd_q.op  <= ttpq_pkg::ROP_INSERT;
						rcmd_q.ent <= ad_q;
						state_q    <= S_AD_INS_W;
					end else if (lt) begin
						rcmd_q.go <= 1'b1;
						rcmd_q.op <= ttpq_pkg::ROP_EVICT;
						state_q   <= S_AD_EV_W;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_AD_EV_W: begin
					if (rstat.done) begin
						rcmd_q.go  <= 1'b1;
						rcmd_q.op  <= ttpq_pkg::ROP_INSERT;
						rcmd_q.ent <= ad_q;
						state_q    <= S_AD_INS_W;
					end
				end
				S_AD_INS_W: begin
					if (rstat.done) begin
						state_q <= S_FIN;
					end
				end
				S_DQ: begin
					i_q <= '0;
					if (hstat.cnt == '0 && rstat.cnt == '0 && pcnt_q != '0) begin
						state_q <= S_RB_RD;
					end else begin
						state_q <= S_DQ_TAKE;
					end
				end
				S_RB_RD: begin
					if (i_q < pcnt_q) begin
						state_q <= S_RB_PUSH;
					end else begin
						pcnt_q  <= '0;
						state_q <= S_DQ_TAKE;
					end
				end
				S_RB_PUSH: begin
					hcmd_q.go  <= 1'b1;
					hcmd_q.op  <= ttpq_pkg::HOP_PUSH;
					hcmd_q.ent <= pile_rd;
					state_q    <= S_RB_PUSH_W;
				end
				S_RB_PUSH_W: begin
					if (hstat.done) begin
						if (hstat.cnt > m_eff) begin
							hcmd_q.go <= 1'b1;
							hcmd_q.op <= ttpq_pkg::HOP_POP;
							state_q   <= S_RB_POP_W;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_RB_RD;
						end
					end
				end
				S_RB_POP_W: begin
					if (hstat.done) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_RB_RD;
					end
				end
				S_DQ_TAKE: begin
					if (hstat.cnt == '0) begin
						state_q <= S_FIN;
					end else begin
						hcmd_q.go <= 1'b1;
						hcmd_q.op <= ttpq_pkg::HOP_LAST;
						state_q   <= S_DQ_TAKE_W;
					end
				end
				S_DQ_TAKE_W: begin
					if (hstat.done) begin
						out_q <= hstat.res;
						got_q <= 1'b1;
						if (rstat.cnt != '0) begin
							rcmd_q.go <= 1'b1;
							rcmd_q.op <= ttpq_pkg::ROP_MAX;
							state_q   <= S_DQ_RMAX_W;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_DQ_RMAX_W: begin
					if (rstat.done) begin
						hcmd_q.go  <= 1'b1;
						hcmd_q.op  <= ttpq_pkg::HOP_PUSH;
						hcmd_q.ent <= rstat.res;
						state_q    <= S_DQ_PUSH_W;
					end
				end
				S_DQ_PUSH_W: begin
					if (hstat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign got_entry  = got_q;
	assign out_id     = out_q.id;
	assign out_handle = out_q.handle;
	assign out_score  = out_q.score;
	assign dropped    = drop_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a command is in progress");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_heap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (hstat.cnt <= ttpq_pkg::HEAP_CW'(ttpq_pkg::HEAP_DEPTH)))
		else $error("heap count above tier size at rest");

	a_runner_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rstat.cnt <= ttpq_pkg::RUN_CW'(ttpq_pkg::RUNNER_DEPTH))
		else $error("runner count above list size");

endmodule

>>> verif/ttpq_checker.sv
`timescale 1ns / 1ps

module ttpq_checker
	import ttpq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic                op,
	input  logic [31:0]         item_id,
	input  logic [31:0]         item_handle,
	input  logic [31:0]         item_score,
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                done,
	input  logic                got_entry,
	input  logic [31:0]         out_id,
	input  logic [31:0]         out_handle,
	input  logic [31:0]         out_score,
	input  logic                dropped,
	output int                  pending,
	output int                  fails
);

	typedef struct {
		logic   got;
		entry_t ent;
		logic   drop;
	} answer_t;

	// mirror of the queue contents
	entry_t      heap [HEAP_SLOTS];
	entry_t      runners [RUNNER_DEPTH];
	entry_t      pile [PILE_DEPTH];
	int unsigned heap_n, runner_n, pile_n;
	logic [GOOD_W-1:0] good_lim;
	logic [RLIM_W-1:0] runner_lim;
	answer_t     answers_q [$];

	function automatic int unsigned top_m();
		if (good_lim < 1) return 1;
		if (good_lim > HEAP_DEPTH) return HEAP_DEPTH;
		return good_lim;
	endfunction

	function automatic int unsigned top_r();
		if (runner_lim > RUNNER_DEPTH) return RUNNER_DEPTH;
		return runner_lim;
	endfunction

	function automatic void heap_insert(entry_t e);
		int unsigned pos, p;
		pos = heap_n;
		if (pos > HEAP_DEPTH) return;
		heap_n++;
		while (pos > 0) begin
			p = (pos - 1) / 2;
			if (heap[p].score > e.score) begin
				heap[pos] = heap[p];
				pos = p;
			end else break;
		end
		heap[pos] = e;
	endfunction

	function automatic entry_t heap_take_min();
		entry_t top, last;
		int unsigned pos, l, c;
		top = '0;
		pos = 0;
		if (heap_n == 0) return top;
		top = heap[0];
		heap_n--;
		if (heap_n == 0) return top;
		last = heap[heap_n];
		while (2 * pos + 1 < heap_n) begin
			l = 2 * pos + 1;
			c = l;
			if (l + 1 < heap_n && heap[l + 1].score < heap[l].score) c = l + 1;
			if (heap[c].score < last.score) begin
				heap[pos] = heap[c];
				pos = c;
			end else break;
		end
		heap[pos] = last;
		return top;
	endfunction

	function automatic logic pile_add(entry_t e);
		if (pile_n >= PILE_DEPTH) return 1'b1;
		pile[pile_n] = e;
		pile_n++;
		return 1'b0;
	endfunction

	// sorted ascending, new entry lands ahead of equal scores
	function automatic void runner_place(entry_t e);
		int unsigned lo, hi, mid;
		lo = 0;
		hi = runner_n;
		if (runner_n >= RUNNER_DEPTH) return;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (runners[mid].score < e.score) lo = mid + 1;
			else hi = mid;
		end
		for (int unsigned i = runner_n; i > lo; i--) runners[i] = runners[i - 1];
		runners[lo] = e;
		runner_n++;
	endfunction

	function automatic logic demote(entry_t e);
		logic lost;
		if (top_r() == 0) return pile_add(e);
		if (runner_n < top_r()) begin
			runner_place(e);
			return 1'b0;
		end
		if (runner_n > 0 && e.score > runners[0].score) begin
			lost = pile_add(runners[0]);
			runner_n--;
			for (int unsigned i = 0; i < runner_n; i++) runners[i] = runners[i + 1];
			runner_place(e);
			return lost;
		end
		return pile_add(e);
	endfunction

	function automatic void refill_from_pile();
		entry_t spill;
		if (pile_n == 0) return;
		heap_n = 0;
		for (int unsigned i = 0; i < pile_n; i++) begin
			heap_insert(pile[i]);
			if (heap_n > top_m()) spill = heap_take_min();
		end
		pile_n = 0;
		runner_n = 0;
	endfunction

	function automatic answer_t queue_op(logic is_deq, entry_t e);
		answer_t a;
		entry_t  ousted;
		a.got = 1'b0;
		a.ent = '0;
		a.drop = 1'b0;
		if (is_deq == OP_ENQ) begin
			if (heap_n < top_m()) heap_insert(e);
			else if (e.score > heap[0].score) begin
				ousted = heap_take_min();
				heap_insert(e);
				a.drop = demote(ousted);
			end else a.drop = demote(e);
			return a;
		end
		if (heap_n == 0 && runner_n == 0) refill_from_pile();
		if (heap_n == 0 || heap_n > HEAP_DEPTH) return a;
		heap_n--;
		a.got = 1'b1;
		a.ent = heap[heap_n];
		if (runner_n > 0) begin
			runner_n--;
			heap_insert(runners[runner_n]);
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		entry_t  e;
		if (!arst_n) begin
			heap_n = 0;
			runner_n = 0;
			pile_n = 0;
			good_lim = GOOD_RST;
			runner_lim = RLIM_RST;
			answers_q.delete();
			pending <= 0;
			fails <= 0;
		end else begin
			// a result strobe belongs to an earlier transfer, so check it first
			if (done) begin
				if (answers_q.size() == 0) begin
					$error("unexpected result strobe");
					fails <= fails + 1;
				end else begin
					want = answers_q.pop_front();
					if (got_entry !== want.got || out_id !== want.ent.id ||
					    out_handle !== want.ent.handle || out_score !== want.ent.score ||
					    dropped !== want.drop) begin
						fails <= fails + 1;
						if (got_entry !== want.got)
							$error("got_entry: expected %0d, actual %0d", want.got, got_entry);
						if (out_id !== want.ent.id)
							$error("out_id: expected %0h, actual %0h", want.ent.id, out_id);
						if (out_handle !== want.ent.handle)
							$error("out_handle: expected %0h, actual %0h",
							       want.ent.handle, out_handle);
						if (out_score !== want.ent.score)
							$error("out_score: expected %0h, actual %0h",
							       want.ent.score, out_score);
						if (dropped !== want.drop)
							$error("dropped: expected %0d, actual %0d", want.drop, dropped);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_GOOD_LIMIT) good_lim = cfg_data[GOOD_W-1:0];
				else if (cfg_index == REG_RUNNER_LIMIT) runner_lim = cfg_data[RLIM_W-1:0];
			end
			if (start && !busy) begin
				e.id = item_id;
				e.handle = item_handle;
				e.score = item_score;
				answers_q.push_back(queue_op(op, e));
			end
			pending <= answers_q.size();
		end
	end

endmodule

>>> verif/tb_three_tier_top_m_priority_queue.sv
`timescale 1ns / 1ps

module tb_three_tier_top_m_priority_queue;
	import ttpq_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              op;
	logic [31:0]       item_id;
	logic [31:0]       item_handle;
	logic [31:0]       item_score;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              done;
	logic              got_entry;
	logic [31:0]       out_id;
	logic [31:0]       out_handle;
	logic [31:0]       out_score;
	logic              dropped;
	int                pending;
	int                fails;
	bit                idling;  // random gaps between commands on/off

	three_tier_top_m_priority_queue DUT (.*);
	ttpq_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Whole run is bounded; a rebuild over a full pile is the slow path.
	initial begin
		#40ms;
		$display("three_tier_top_m_priority_queue regression: fail");
		$finish;
	end

	// Mostly back to back, some short gaps, a few long ones.
	function automatic int pick_gap();
		int roll;
		if (!idling) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Called at a rising edge; returns at the edge where the transfer happens.
	// start stays high into the next command when there is no gap, so it
	// gets only one assignment per edge.
	task automatic issue(logic is_deq, logic [31:0] id, logic [31:0] hnd, logic [31:0] sc);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= is_deq;
		item_id <= id;
		item_handle <= hnd;
		item_score <= sc;
		// busy is stable mid-cycle, so sample it on the falling edge
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	// Small score range gives plenty of ties.
	task automatic issue_random(int deq_pct);
		logic [31:0] sc;
		sc = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom;
		issue(($urandom_range(0, 99) < deq_pct) ? OP_DEQ : OP_ENQ, $urandom, $urandom, sc);
	endtask

	// Let every outstanding result land before touching the limits.
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		@(posedge clk);
	endtask

	task automatic write_limit(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_limits(logic [CFG_W-1:0] m, logic [CFG_W-1:0] r);
		drain();
		write_limit(REG_GOOD_LIMIT, m);
		write_limit(REG_RUNNER_LIMIT, r);
	endtask

	initial begin
		logic [CFG_W-1:0] m_set [6];
		logic [CFG_W-1:0] r_set [6];
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_ENQ;
		item_id = '0;
		item_handle = '0;
		item_score = '0;
		cfg_we = 1'b0;
		cfg_index = REG_GOOD_LIMIT;
		cfg_data = '0;
		idling = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty dequeue, field extremes, ties, a few dequeues.
		issue(OP_DEQ, '0, '0, '0);
		issue(OP_ENQ, '0, '0, '0);
		issue(OP_ENQ, '1, '1, '1);
		issue(OP_ENQ, 32'h1, 32'h2, 32'h5);
		issue(OP_ENQ, 32'h3, 32'h4, 32'h5);
		issue(OP_ENQ, 32'h5, 32'h6, 32'h5);
		issue(OP_ENQ, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000);
		repeat (8) issue(OP_DEQ, '0, '0, '0);

		// Tiny heap, no runner list: ties stay out, the pile overflows and
		// drops, then the rebuild pass takes the single best pile entry.
		set_limits(7'd1, 7'd0);
		issue(OP_ENQ, 32'h10, 32'h11, 32'h7);
		issue(OP_ENQ, 32'h12, 32'h13, 32'h7);
		issue(OP_ENQ, 32'h14, 32'h15, 32'h8);
		idling = 1'b1;
		repeat (1040) issue_random(0);
		repeat (6) issue(OP_DEQ, $urandom, $urandom, $urandom);

		// Limit sweeps incl. out-of-range values that clamp; state carries
		// over, so lowered limits also hit already-full tiers.
		m_set = '{7'd64, 7'd0, 7'd127, 7'd3, 7'd1, 7'd65};
		r_set = '{7'd16, 7'd31, 7'd17, 7'd2, 7'd0, 7'd1};
		for (int ph = 0; ph < 6; ph++) begin
			set_limits(m_set[ph], r_set[ph]);
			idling = (ph != 2);
			repeat (60) issue_random(25);
			repeat (30) issue_random(70);
		end
		set_limits(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(0, 16)));
		repeat (60) issue_random(40);

		drain();
		repeat (100) @(posedge clk);
		if (fails == 0)
			$display("three_tier_top_m_priority_queue regression: pass");
		else
			$display("three_tier_top_m_priority_queue regression: fail");
		$finish;
	end

endmodule
